>>> sv/text_codepage_transcoder_defines.svh
// Assertion macros for the text codepage transcoder.
// Included by the top level; no other dependencies.
`ifndef TEXT_CODEPAGE_TRANSCODER_DEFINES_SVH
`define TEXT_CODEPAGE_TRANSCODER_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication, disabled during reset.
`define TCT_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication, disabled during reset.
`define TCT_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);
`else
`define TCT_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg)
`define TCT_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg)
`endif

`endif

>>> sv/tct_pkg.sv
// Types, codes and code-point helpers for the text codepage transcoder.
// No dependencies; used by the top level, tct_front, tct_fifo and tct_back.
package tct_pkg;

    localparam logic [1:0] SRC_UTF8    = 2'd0;
    localparam logic [1:0] SRC_UTF16LE = 2'd1;
    localparam logic [1:0] SRC_CP1251  = 2'd2;
    localparam logic [1:0] SRC_RAW     = 2'd3;

    localparam logic [2:0] TGT_UTF8    = 3'd0;
    localparam logic [2:0] TGT_CP1251  = 3'd1;
    localparam logic [2:0] TGT_UTF16LE = 3'd2;
    localparam logic [2:0] TGT_UTF16BE = 3'd3;

    localparam logic [1:0] CFG_SOURCE  = 2'd0;
    localparam logic [1:0] CFG_TARGET  = 2'd1;
    localparam logic [1:0] CFG_LIMIT   = 2'd2;

    localparam logic [1:0] LEAD_NONE   = 2'd0;
    localparam logic [1:0] LEAD_UTF8_2 = 2'd1;
    localparam logic [1:0] LEAD_UTF8_3 = 2'd2;
    localparam logic [1:0] LEAD_UTF16  = 2'd3;

    localparam logic [15:0] LIMIT_RESET = 16'hFFFF;

    // One decoded step handed from the front to the back.
    typedef struct packed {
        logic        done;   // a code point completed
        logic [15:0] cp;
        logic        eob;    // block ends here
    } t_work;

    function automatic logic [15:0] w1251_in(input logic [7:0] b);
        logic [15:0] r;
        if (b >= 8'hC0) begin
            r = {8'h00, b} - 16'h00C0 + 16'h0410;
        end else begin
            unique case (b)
                8'hB2:   r = 16'h0406;
                8'hAF:   r = 16'h0407;
                8'hB3:   r = 16'h0456;
                8'hBF:   r = 16'h0457;
                default: r = {8'h00, b};
            endcase
        end
        return r;
    endfunction

    function automatic logic [7:0] w1251_out(input logic [15:0] cp);
        logic [7:0] r;
        if (cp >= 16'h0410 && cp <= 16'h044F) begin
            r = cp[7:0] - 8'h10 + 8'hC0;
        end else begin
            unique case (cp)
                16'h0406: r = 8'hB2;
                16'h0407: r = 8'hAF;
                16'h0456: r = 8'hB3;
                16'h0457: r = 8'hBF;
                default:  r = cp[7:0];
            endcase
        end
        return r;
    endfunction

    // Number of bytes one code point takes in the target codepage.
    function automatic logic [1:0] char_len(input logic [15:0] cp, input logic [2:0] tgt);
        logic [1:0] r;
        unique case (tgt)
            TGT_UTF8: begin
                if (cp < 16'd128)       r = 2'd1;
                else if (cp < 16'd2048) r = 2'd2;
                else                    r = 2'd3;
            end
            TGT_UTF16LE, TGT_UTF16BE: r = 2'd2;
            default:                  r = 2'd1;
        endcase
        return r;
    endfunction

    // Byte idx of a code point in the target codepage.
    function automatic logic [7:0] char_byte(input logic [15:0] cp, input logic [2:0] tgt,
                                             input logic [1:0] idx);
        logic [7:0] r;
        unique case (tgt)
            TGT_UTF8: begin
                if (cp < 16'd128) begin
                    r = cp[7:0];
                end else if (cp < 16'd2048) begin
                    r = (idx == 2'd0) ? {3'b110, cp[10:6]} : {2'b10, cp[5:0]};
                end else begin
                    unique case (idx)
                        2'd0:    r = {4'hE, cp[15:12]};
                        2'd1:    r = {2'b10, cp[11:6]};
                        default: r = {2'b10, cp[5:0]};
                    endcase
                end
            end
            TGT_CP1251:  r = w1251_out(cp);
            TGT_UTF16LE: r = (idx == 2'd0) ? cp[7:0] : cp[15:8];
            TGT_UTF16BE: r = (idx == 2'd0) ? cp[15:8] : cp[7:0];
            default:     r = cp[7:0];
        endcase
        return r;
    endfunction

endpackage

>>> sv/tct_in_if.sv
// Input channel of the transcoder: one source byte per beat.
// Standalone; no package dependency.
interface tct_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       end_of_block;

    modport source (output valid, output in_byte, output end_of_block, input ready);
    modport sink   (input valid, input in_byte, input end_of_block, output ready);
endinterface

>>> sv/tct_out_if.sv
// Output channel of the transcoder: one converted byte per beat.
// Standalone; no package dependency.
interface tct_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       is_terminator;
    logic       last_of_run;

    modport source (output valid, output out_byte, output is_terminator,
                    output last_of_run, input ready);
    modport sink   (input valid, input out_byte, input is_terminator,
                    input last_of_run, output ready);
endinterface

>>> sv/text_codepage_transcoder.sv
// Text codepage transcoder. Source bytes (UTF-8 up to three bytes, UTF-16LE,
// Windows-1251 or raw) enter on i_src, one byte per beat; the front end gathers
// each character into a 16-bit code point and hands it through a short queue to
// the back end, which re-encodes it (UTF-8, Windows-1251, UTF-16LE/BE or raw) and
// sends one byte per beat on o_dst. A beat flagged end_of_block appends one zero
// terminator (two for UTF-16 targets) and clears the block state, dropping any
// incomplete sequence. No more than the limit (i_cfg_idx 2) bytes, terminators included, leave
// in a block; last_of_run marks the final byte caused by each input beat.
// Rate: the back end emits one output byte per cycle while o_dst is ready; an
// input beat produces zero to four bytes (three for a three-byte UTF-8 target
// character), and none when all of its bytes fall beyond the limit.
// The input side takes a beat per cycle while the FIFO_DEPTH-entry queue has
// room; beats that only open a sequence bypass the queue entirely. Configuration
// goes through i_cfg_we / i_cfg_idx / i_cfg_data (0 source, 1 target, 2 limit)
// and must be written only while the block is idle.
// Depends on tct_pkg, tct_in_if, tct_out_if, tct_front, tct_fifo, tct_back.
`include "text_codepage_transcoder_defines.svh"

module text_codepage_transcoder import tct_pkg::*; #(
    parameter int FIFO_DEPTH = 2
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_data,
    tct_in_if.sink      i_src,
    tct_out_if.source   o_dst
);

    // Configuration registers.
    logic [1:0]  r_source;
    logic [2:0]  r_target;
    logic [15:0] r_limit;

    // Front-to-queue and queue-to-back links.
    logic  push, full, pop, q_valid;
    t_work push_work, q_work;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_source <= SRC_UTF8;
            r_target <= TGT_UTF8;
            r_limit  <= LIMIT_RESET;
        end else if (i_cfg_we) begin
            // Writes to an index past the register list are dropped.
            unique case (i_cfg_idx)
                CFG_SOURCE: r_source <= i_cfg_data[1:0];
                CFG_TARGET: r_target <= i_cfg_data[2:0];
                CFG_LIMIT:  r_limit  <= i_cfg_data;
                default:    ;
            endcase
        end
    end

    // Decode: gather multi-byte sequences, hold partial state across beats.
    tct_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_source (r_source),
        .i_full   (full),
        .i_src    (i_src),
        .o_push   (push),
        .o_work   (push_work)
    );

    // Decouple: let decode run ahead while the encoder drains a long character.
    tct_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_work),
        .i_pop   (pop),
        .o_full  (full),
        .o_valid (q_valid),
        .o_data  (q_work)
    );

    // Encode: expand each code point into bytes, clip at the limit.
    tct_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_target (r_target),
        .i_limit  (r_limit),
        .i_valid  (q_valid),
        .i_work   (q_work),
        .o_pop    (pop),
        .o_dst    (o_dst)
    );

    // The front end must never push into a full queue.
    `TCT_ASSERT_IMP(a_no_overflow, i_clk, i_rst_n, push, !full, "push into full queue")
    // The back end pops only real entries.
    `TCT_ASSERT_IMP(a_no_underflow, i_clk, i_rst_n, pop, q_valid, "pop from empty queue")
    // Terminator beats always carry a zero byte.
    `TCT_ASSERT_IMP(a_term_zero, i_clk, i_rst_n, o_dst.valid && o_dst.is_terminator,
                    o_dst.out_byte == 8'h00, "terminator with nonzero byte")
    // Every pushed entry carries a completed character, an end of block, or both.
    `TCT_ASSERT_IMP(a_push_meaningful, i_clk, i_rst_n, push,
                    push_work.done || push_work.eob, "empty work pushed")

endmodule

>>> sv/tct_front.sv
// Front end: accepts source bytes and gathers them into code points.
// Depends on tct_pkg and tct_in_if.
module tct_front import tct_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic [1:0]  i_source,
    input  logic        i_full,
    tct_in_if.sink      i_src,
    output logic        o_push,
    output t_work       o_work
);

    logic [1:0]  r_pend,  n_pend;
    logic [15:0] r_part,  n_part;
    logic [1:0]  r_lead,  n_lead;

    logic        acc;
    logic        done;
    logic [15:0] cp;
    logic [15:0] d;
    logic [7:0]  b;

    assign i_src.ready = !i_full;
    assign acc         = i_src.valid && !i_full;
    assign b           = i_src.in_byte;

    always_comb begin
        n_pend = r_pend;
        n_part = r_part;
        n_lead = r_lead;
        done   = 1'b0;
        cp     = '0;
        d      = {8'h00, b} - 16'd128;
        if (r_pend != 2'd0) begin
            if (r_lead == LEAD_UTF16) begin
                cp     = r_part | {b, 8'h00};
                n_pend = 2'd0;
                done   = 1'b1;
            end else begin
                if (r_pend == 2'd2) begin
                    d = {d[9:0], 6'b0};
                end
                n_part = r_part + d;
                n_pend = r_pend - 2'd1;
                if (r_pend == 2'd1) begin
                    cp   = n_part;
                    done = 1'b1;
                end
            end
            if (done) begin
                n_lead = LEAD_NONE;
                n_part = '0;
            end
        end else begin
            unique case (i_source)
                SRC_UTF8: begin
                    if (b >= 8'd192 && b <= 8'd223) begin
                        n_part = {5'b0, b[4:0], 6'b0};
                        n_pend = 2'd1;
                        n_lead = LEAD_UTF8_2;
                    end else if (b >= 8'd224 && b <= 8'd239) begin
                        n_part = {b[3:0], 12'b0};
                        n_pend = 2'd2;
                        n_lead = LEAD_UTF8_3;
                    end else begin
                        cp   = {8'h00, b};
                        done = 1'b1;
                    end
                end
                SRC_UTF16LE: begin
                    n_part = {8'h00, b};
                    n_pend = 2'd1;
                    n_lead = LEAD_UTF16;
                end
                SRC_CP1251: begin
                    cp   = w1251_in(b);
                    done = 1'b1;
                end
                default: begin
                    cp   = {8'h00, b};
                    done = 1'b1;
                end
            endcase
        end
        // End of block drops any open sequence.
        if (i_src.end_of_block) begin
            n_pend = 2'd0;
            n_part = '0;
            n_lead = LEAD_NONE;
        end
    end

    // Beats that yield neither a character nor a terminator never reach the queue.
    assign o_push       = acc && (done || i_src.end_of_block);
    assign o_work.done  = done;
    assign o_work.cp    = cp;
    assign o_work.eob   = i_src.end_of_block;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= 2'd0;
            r_part <= '0;
            r_lead <= LEAD_NONE;
        end else if (acc) begin
            r_pend <= n_pend;
            r_part <= n_part;
            r_lead <= n_lead;
        end
    end

endmodule

>>> sv/tct_fifo.sv
// Short queue of decoded work between front and back ends.
// Depends on tct_pkg.
module tct_fifo import tct_pkg::*; #(
    parameter int DEPTH = 2
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_work i_data,
    input  logic  i_pop,
    output logic  o_full,
    output logic  o_valid,
    output t_work o_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_work             r_mem [DEPTH];
    logic [PTR_W-1:0]  r_wr, r_rd;
    logic [CNT_W-1:0]  r_cnt;
    logic              do_push, do_pop;

    assign o_full  = (r_cnt == CNT_W'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + PTR_W'(1);
            end
            if (do_pop) begin
                r_rd <= (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + PTR_W'(1);
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + CNT_W'(1);
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - CNT_W'(1);
            end
        end
    end

endmodule

>>> sv/tct_back.sv
// Back end: encodes each code point, appends terminators, enforces the byte limit.
// Depends on tct_pkg and tct_out_if.
module tct_back import tct_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic [2:0]  i_target,
    input  logic [15:0] i_limit,
    input  logic        i_valid,
    input  t_work       i_work,
    output logic        o_pop,
    tct_out_if.source   o_dst
);

    logic        r_busy;
    t_work       r_work;
    logic [2:0]  r_idx;
    logic [15:0] r_cnt;
    logic        r_ov;
    logic [7:0]  r_byte;
    logic        r_term;
    logic        r_last;

    logic [1:0]  nchar;
    logic [1:0]  nterm;
    logic [2:0]  total;
    logic [15:0] cnt_inc;
    logic        room, have, slot_free, emit, finish, last, in_char;
    logic [7:0]  byte_val;

    always_comb begin
        nchar     = r_work.done ? char_len(r_work.cp, i_target) : 2'd0;
        nterm     = !r_work.eob ? 2'd0 :
                    (i_target == TGT_UTF16LE || i_target == TGT_UTF16BE) ? 2'd2 : 2'd1;
        total     = {1'b0, nchar} + {1'b0, nterm};
        cnt_inc   = r_cnt + 16'd1;
        room      = r_cnt < i_limit;
        have      = r_busy && room && (r_idx < total);
        slot_free = !r_ov || o_dst.ready;
        emit      = have && slot_free;
        last      = (total == r_idx + 3'd1) || (cnt_inc == i_limit);
        finish    = r_busy && (!have || (emit && last));
        in_char   = r_idx < {1'b0, nchar};
        byte_val  = in_char ? char_byte(r_work.cp, i_target, r_idx[1:0]) : 8'h00;
    end

    assign o_pop = i_valid && (!r_busy || finish);

    assign o_dst.valid         = r_ov;
    assign o_dst.out_byte      = r_byte;
    assign o_dst.is_terminator = r_term;
    assign o_dst.last_of_run   = r_last;

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_work <= i_work;
        end
        if (emit) begin
            r_byte <= byte_val;
            r_term <= !in_char;
            r_last <= last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= '0;
            r_cnt  <= '0;
            r_ov   <= 1'b0;
        end else begin
            if (o_pop) begin
                r_busy <= 1'b1;
                r_idx  <= '0;
            end else begin
                if (finish) begin
                    r_busy <= 1'b0;
                end
                if (emit) begin
                    r_idx <= r_idx + 3'd1;
                end
            end
            if (finish && r_work.eob) begin
                r_cnt <= '0;
            end else if (emit) begin
                r_cnt <= cnt_inc;
            end
            if (emit) begin
                r_ov <= 1'b1;
            end else if (o_dst.ready) begin
                r_ov <= 1'b0;
            end
        end
    end

endmodule
